// ----- hdl/bots_pkg.sv -----
// Shared types, codes and helper functions of the bulk-only transport sequencer.
`timescale 1ns / 1ps

package bots_pkg;

	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_CMD  = 3'd1,
		ST_IN   = 3'd2,
		ST_OUT  = 3'd3,
		ST_STS  = 3'd4
	} stage_t;

	typedef enum logic [1:0] {
		CMD_OUT_PKT     = 2'd0,
		CMD_WRAP_BYTE   = 2'd1,
		CMD_SECTOR_DONE = 2'd2,
		CMD_STATUS      = 2'd3
	} cmd_t;

	// SCSI operation codes
	localparam logic [7:0] OP_SENSE      = 8'h03;
	localparam logic [7:0] OP_INQUIRY    = 8'h12;
	localparam logic [7:0] OP_MODE6      = 8'h1A;
	localparam logic [7:0] OP_REMOVAL    = 8'h1E;
	localparam logic [7:0] OP_FMT_CAP    = 8'h23;
	localparam logic [7:0] OP_CAPACITY   = 8'h25;
	localparam logic [7:0] OP_READ10     = 8'h28;
	localparam logic [7:0] OP_WRITE10    = 8'h2A;
	localparam logic [7:0] OP_VERIFY     = 8'h2F;
	localparam logic [7:0] OP_MODE10     = 8'h5A;

	// canned reply codes
	localparam logic [3:0] REPLY_NONE     = 4'd0;
	localparam logic [3:0] REPLY_SENSE    = 4'd1;
	localparam logic [3:0] REPLY_INQUIRY  = 4'd2;
	localparam logic [3:0] REPLY_MODE6    = 4'd3;
	localparam logic [3:0] REPLY_REMOVAL  = 4'd4;
	localparam logic [3:0] REPLY_FMT_CAP  = 4'd5;
	localparam logic [3:0] REPLY_CAPACITY = 4'd6;
	localparam logic [3:0] REPLY_VERIFY   = 4'd7;
	localparam logic [3:0] REPLY_MODE10   = 4'd8;

	// byte positions inside the 31-byte command wrapper
	localparam logic [4:0] IDX_TAG_LO   = 5'd4;
	localparam logic [4:0] IDX_TAG_HI   = 5'd7;
	localparam logic [4:0] IDX_LEN_LO   = 5'd8;
	localparam logic [4:0] IDX_LEN_HI   = 5'd11;
	localparam logic [4:0] IDX_OPCODE   = 5'd15;
	localparam logic [4:0] IDX_LBA_HI   = 5'd17;
	localparam logic [4:0] IDX_LBA_LO   = 5'd20;
	localparam logic [4:0] IDX_WRAP_END = 5'd30;

	localparam logic [31:0] NO_PAGE = 32'hEFFF_FFFF;

	// status wrapper: 13 bytes, index of the final one
	localparam logic [3:0] CSW_LAST_IDX = 4'd12;

	typedef struct packed {
		stage_t      stage;
		logic [3:0]  reply;
		logic [29:0] page;
		logic [1:0]  slot;
		logic        access;
		logic        sval;
		logic        burst;
	} res_t;

	function automatic logic [3:0] reply_of(input logic [7:0] op);
		logic [3:0] r;
		case (op)
			OP_SENSE:    r = REPLY_SENSE;
			OP_INQUIRY:  r = REPLY_INQUIRY;
			OP_MODE6:    r = REPLY_MODE6;
			OP_REMOVAL:  r = REPLY_REMOVAL;
			OP_FMT_CAP:  r = REPLY_FMT_CAP;
			OP_CAPACITY: r = REPLY_CAPACITY;
			OP_VERIFY:   r = REPLY_VERIFY;
			OP_MODE10:   r = REPLY_MODE10;
			default:     r = REPLY_NONE;
		endcase
		return r;
	endfunction

	// signature "USBS", tag little-endian, then residue and status all zero
	function automatic logic [7:0] csw_byte(input logic [3:0] idx, input logic [31:0] tag);
		logic [7:0] b;
		case (idx)
			4'd0:    b = 8'h55;
			4'd1:    b = 8'h53;
			4'd2:    b = 8'h42;
			4'd3:    b = 8'h53;
			4'd4:    b = tag[7:0];
			4'd5:    b = tag[15:8];
			4'd6:    b = tag[23:16];
			4'd7:    b = tag[31:24];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ----- hdl/bots_cdiv.sv -----
// Pipelined divider by a constant: reciprocal multiply split in two partial products.
`timescale 1ns / 1ps

module bots_cdiv #(
	parameter int unsigned XW = 32,
	parameter int unsigned D  = 4
) (
	input  logic                     clk,
	input  logic [XW-1:0]            x,
	output logic [XW-1:0]            quo,
	output logic [$clog2(D+1)-1:0]   rem
);
	localparam int unsigned DW = $clog2(D + 1);
	localparam int unsigned S  = XW + DW;
	localparam int unsigned MW = S + 1;
	localparam int unsigned LW = MW / 2;
	localparam int unsigned HW = MW - LW;
	localparam logic [63:0] MAGIC = ((64'd1 << S) + 64'(D) - 64'd1) / 64'(D);
	localparam logic [LW-1:0] M_LO = MAGIC[LW-1:0];
	localparam logic [HW-1:0] M_HI = MAGIC[LW +: HW];
	localparam logic [XW-1:0] DV = XW'(D);

	logic [XW+LW-1:0] plo_s1;
	logic [XW+HW-1:0] phi_s1;
	logic [XW-1:0]    x_s1;
	logic [XW+MW-1:0] sum;
	logic [XW-1:0]    q_s2;
	logic [XW-1:0]    x_s2;
	logic [XW-1:0]    diff;
	logic [XW-1:0]    q_s3;
	logic [DW-1:0]    r_s3;

	assign sum  = {phi_s1, {LW{1'b0}}} + {{HW{1'b0}}, plo_s1};
	assign diff = x_s2 - q_s2 * DV;

	always_ff @(posedge clk) begin
		plo_s1 <= {{LW{1'b0}}, x} * {{XW{1'b0}}, M_LO};
		phi_s1 <= {{HW{1'b0}}, x} * {{XW{1'b0}}, M_HI};
		x_s1   <= x;
		q_s2   <= sum[S +: XW];
		x_s2   <= x_s1;
		q_s3   <= q_s2;
		r_s3   <= diff[DW-1:0];
	end

	assign quo = q_s3;
	assign rem = r_s3;

endmodule

// ----- hdl/bots_core.sv -----
// Transport state: wrapper collection, decode, sector walk and status entry.
`timescale 1ns / 1ps

module bots_core import bots_pkg::*; #(
	parameter int unsigned SECTOR_BYTES     = 512,
	parameter int unsigned SECTORS_PER_PAGE = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic [1:0]  cmd,
	input  logic [7:0]  wbyte,
	output res_t        res,
	output logic [31:0] tag
);
	localparam int unsigned SW  = (SECTORS_PER_PAGE > 1) ? $clog2(SECTORS_PER_PAGE) : 1;
	localparam int unsigned ARW = $clog2(SECTORS_PER_PAGE + 1);
	localparam int unsigned LRW = $clog2(SECTOR_BYTES + 1);
	localparam logic [SW-1:0] SLOT_LAST = SW'(SECTORS_PER_PAGE - 1);

	stage_t        stage_q, stage_n;
	logic [4:0]    idx_q, idx_n;
	logic [31:0]   tag_q, tag_n;
	logic [31:0]   len_q, len_n;
	logic [7:0]    op_q, op_n;
	logic [31:0]   pend_q, pend_n;
	logic [31:0]   addr_q, addr_n;
	logic [23:0]   left_q, left_n;
	logic [31:0]   prev_q, prev_n;
	logic [31:0]   page_q, page_n;
	logic [SW-1:0] slot_q, slot_n;

	logic [31:0]   len_quo;
	logic [LRW-1:0] len_rem;
	logic [31:0]   addr_quo;
	logic [ARW-1:0] addr_rem;
	logic [31:0]   secs32;
	logic [23:0]   secs;
	logic [3:0]    reply;

	bots_cdiv #(.XW(32), .D(SECTOR_BYTES)) u_len_div (
		.clk (clk),
		.x   (len_q),
		.quo (len_quo),
		.rem (len_rem)
	);

	bots_cdiv #(.XW(32), .D(SECTORS_PER_PAGE)) u_addr_div (
		.clk (clk),
		.x   (pend_q),
		.quo (addr_quo),
		.rem (addr_rem)
	);

	assign secs32 = len_quo + 32'(len_rem != '0);
	assign secs   = secs32[23:0];
	assign reply  = reply_of(op_q);

	always_comb begin
		stage_n = stage_q;
		idx_n   = idx_q;
		tag_n   = tag_q;
		len_n   = len_q;
		op_n    = op_q;
		pend_n  = pend_q;
		addr_n  = addr_q;
		left_n  = left_q;
		prev_n  = prev_q;
		page_n  = page_q;
		slot_n  = slot_q;
		res     = '0;
		case (cmd_t'(cmd))
			CMD_OUT_PKT: begin
				if (stage_q == ST_IDLE || stage_q == ST_CMD) begin
					stage_n = ST_CMD;
					idx_n   = '0;
				end
			end
			CMD_WRAP_BYTE: begin
				if (stage_q == ST_CMD) begin
					case (idx_q) inside
						[IDX_TAG_LO:IDX_TAG_HI]: tag_n[8*idx_q[1:0] +: 8] = wbyte;
						[IDX_LEN_LO:IDX_LEN_HI]: len_n[8*idx_q[1:0] +: 8] = wbyte;
						IDX_OPCODE:              op_n = wbyte;
						[IDX_LBA_HI:IDX_LBA_LO]: pend_n[8*(2'(IDX_LBA_LO - idx_q)) +: 8] = wbyte;
						default: ;
					endcase
					if (idx_q == IDX_WRAP_END) begin
						idx_n  = '0;
						left_n = secs;
						if ((op_q == OP_READ10 || op_q == OP_WRITE10) && secs != '0) begin
							addr_n = pend_q;
							page_n = addr_quo;
							slot_n = SW'(addr_rem);
						end
						if (reply != REPLY_NONE) begin
							stage_n   = ST_STS;
							res.reply = reply;
						end else if (op_q == OP_READ10) begin
							prev_n  = NO_PAGE;
							stage_n = (secs != '0) ? ST_IN : ST_STS;
						end else if (op_q == OP_WRITE10) begin
							stage_n = (secs != '0) ? ST_OUT : ST_STS;
						end
					end else begin
						idx_n = idx_q + 5'd1;
					end
				end
			end
			CMD_SECTOR_DONE: begin
				if (stage_q == ST_IN || stage_q == ST_OUT) begin
					res.sval = 1'b1;
					res.page = page_q[29:0];
					res.slot = 2'(slot_q);
					if (stage_q == ST_IN) begin
						res.access = (page_q != prev_q);
						prev_n     = page_q;
					end else begin
						res.access = (slot_q == SLOT_LAST) || (left_q == 24'd1);
					end
					addr_n = addr_q + 32'd1;
					if (addr_q == '1) begin
						page_n = '0;
						slot_n = '0;
					end else if (slot_q == SLOT_LAST) begin
						page_n = page_q + 32'd1;
						slot_n = '0;
					end else begin
						slot_n = slot_q + SW'(1);
					end
					left_n = left_q - 24'd1;
					if (left_n == '0) begin
						stage_n = ST_STS;
					end
				end
			end
			CMD_STATUS: begin
				if (stage_q == ST_STS) begin
					stage_n   = ST_IDLE;
					res.burst = 1'b1;
				end
			end
			default: ;
		endcase
		res.stage = stage_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= ST_CMD;
			idx_q   <= '0;
			tag_q   <= '0;
			len_q   <= '0;
			op_q    <= '0;
			pend_q  <= '0;
			addr_q  <= '0;
			left_q  <= '0;
			prev_q  <= NO_PAGE;
			page_q  <= '0;
			slot_q  <= '0;
		end else if (fire) begin
			stage_q <= stage_n;
			idx_q   <= idx_n;
			tag_q   <= tag_n;
			len_q   <= len_n;
			op_q    <= op_n;
			pend_q  <= pend_n;
			addr_q  <= addr_n;
			left_q  <= left_n;
			prev_q  <= prev_n;
			page_q  <= page_n;
			slot_q  <= slot_n;
		end
	end

	assign tag = tag_q;

endmodule

// ----- hdl/bots_out.sv -----
// Result register with the 13-byte status wrapper burst.
`timescale 1ns / 1ps

module bots_out import bots_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  res_t        res,
	input  logic [31:0] tag,
	output logic        can_load,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [2:0]  stage,
	output logic [3:0]  reply_kind,
	output logic [29:0] page_number,
	output logic [1:0]  sector_slot,
	output logic        page_access,
	output logic        sector_valid,
	output logic [7:0]  status_byte,
	output logic        status_valid,
	output logic        last
);
	logic        valid_q;
	logic        burst_q;
	res_t        res_q;
	logic [31:0] tag_q;
	logic [3:0]  idx_q;
	logic        last_w;
	logic        pop;

	assign last_w   = !burst_q || (idx_q == CSW_LAST_IDX);
	assign pop      = valid_q && res_ready;
	assign can_load = !valid_q || (res_ready && last_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			burst_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			burst_q <= res.burst;
			idx_q   <= '0;
		end else if (pop) begin
			if (last_w) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
			tag_q <= tag;
		end
	end

	assign res_valid    = valid_q;
	assign stage        = res_q.stage;
	assign reply_kind   = res_q.reply;
	assign page_number  = res_q.page;
	assign sector_slot  = res_q.slot;
	assign page_access  = res_q.access;
	assign sector_valid = res_q.sval;
	assign status_valid = burst_q;
	assign status_byte  = burst_q ? csw_byte(idx_q, tag_q) : 8'h00;
	assign last         = last_w;

endmodule

// ----- hdl/bulk_only_transport_sequencer.sv -----
// Top level of the bulk-only transport sequencer.
`timescale 1ns / 1ps

// Bulk-only transport sequencer. Each request carries one transport event
// (OUT packet ready, command wrapper byte, sector done, status request). A
// request is taken into an input register, runs through one pass of
// combinational decode against the transport state and lands in the result
// register; one request per cycle is sustained as long as results are
// drained. Every request yields one result, except a status request in the
// status stage, which yields the 13-byte status wrapper as 13 results, one
// per cycle while the result side stays ready; the result register
// sequences that burst and holds off the input register meanwhile.
// The sector count (transfer length rounded up to sectors) and the page and
// slot of the block address come from two pipelined constant dividers that
// track the collected fields; the wrapper layout leaves at least ten bytes
// between the last of those fields and the decode, so the quotients are
// always settled in time. The block address is taken big-endian from
// wrapper bytes 17..20; tag and length little-endian.
module bulk_only_transport_sequencer import bots_pkg::*; #(
	parameter int unsigned SECTOR_BYTES     = 512,
	parameter int unsigned SECTORS_PER_PAGE = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  cmd,
	input  logic [7:0]  wrapper_byte,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [2:0]  stage,
	output logic [3:0]  reply_kind,
	output logic [29:0] page_number,
	output logic [1:0]  sector_slot,
	output logic        page_access,
	output logic        sector_valid,
	output logic [7:0]  status_byte,
	output logic        status_valid,
	output logic        last
);
	// input register
	logic        vld_s1;
	logic [1:0]  cmd_s1;
	logic [7:0]  wbyte_s1;

	logic        can_load;
	logic        advance;
	res_t        res;
	logic [31:0] tag;

	// advance the held request when the result register can take its result
	assign advance   = vld_s1 && can_load;
	assign req_ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req_valid && req_ready) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	// hold payload until the next accepted request
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			cmd_s1   <= cmd;
			wbyte_s1 <= wrapper_byte;
		end
	end

	// transport state advances once per request, as it moves to the result register
	bots_core #(
		.SECTOR_BYTES     (SECTOR_BYTES),
		.SECTORS_PER_PAGE (SECTORS_PER_PAGE)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.cmd    (cmd_s1),
		.wbyte  (wbyte_s1),
		.res    (res),
		.tag    (tag)
	);

	// result register; expands a status emission into the wrapper bytes
	bots_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance),
		.res          (res),
		.tag          (tag),
		.can_load     (can_load),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.stage        (stage),
		.reply_kind   (reply_kind),
		.page_number  (page_number),
		.sector_slot  (sector_slot),
		.page_access  (page_access),
		.sector_valid (sector_valid),
		.status_byte  (status_byte),
		.status_valid (status_valid),
		.last         (last)
	);

	// a canned reply always leaves the block in the status stage
	a_reply_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && reply_kind != REPLY_NONE |-> stage == ST_STS)
		else $error("reply named outside status stage");

	// a taken wrapper byte that is not the last keeps the burst going
	a_burst_continues: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && status_valid && !last |=> res_valid && status_valid)
		else $error("status burst cut short");

	// no request advances into the state while a burst is still out
	a_burst_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status_valid && !last |-> !advance)
		else $error("request advanced during status burst");

	// sector reports come only from a data stage; the last one already shows the status stage
	a_sector_stage: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && sector_valid |-> stage == ST_IN || stage == ST_OUT || stage == ST_STS)
		else $error("sector reported outside data stage");

endmodule

// ----- dv/bots_checker.sv -----
// Checker for the bulk-only transport sequencer: predicts results per request and compares.
`timescale 1ns / 1ps

module bots_checker import bots_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_ready,
	input  logic [1:0]  cmd,
	input  logic [7:0]  wrapper_byte,
	input  logic        res_valid,
	input  logic        res_ready,
	input  logic [2:0]  stage,
	input  logic [3:0]  reply_kind,
	input  logic [29:0] page_number,
	input  logic [1:0]  sector_slot,
	input  logic        page_access,
	input  logic        sector_valid,
	input  logic [7:0]  status_byte,
	input  logic        status_valid,
	input  logic        last,
	output int          fails,
	output int          waiting
);

	localparam int unsigned BLOCK_BYTES   = 512;
	localparam int unsigned PAGE_SECTORS  = 4;
	localparam int          STATUS_BYTES  = 13;
	// "USBS" as it goes out on the wire, lowest byte first
	localparam logic [31:0] CSW_SIGNATURE = 32'h5342_5355;

	typedef struct packed {
		stage_t      stage;
		logic [3:0]  reply;
		logic [29:0] page;
		logic [1:0]  slot;
		logic        access;
		logic        sval;
		logic [7:0]  sbyte;
		logic        stval;
		logic        lst;
	} bot_result_t;

	// transport state as the block should hold it
	stage_t      xport_stage;
	logic [4:0]  wrap_pos;
	logic [31:0] cmd_tag;
	logic [31:0] xfer_len;
	logic [7:0]  opcode;
	logic [31:0] lba_pending;
	logic [31:0] lba;
	logic [23:0] sectors_left;
	logic [31:0] fetched_page;

	bot_result_t due_results[$];
	int unsigned results_seen;

	task automatic log_mismatch(input string what);
		$display("[%0t] result %0d: %s", $time, results_seen, what);
		fails++;
	endtask

	task automatic push_result(input logic [3:0] reply, input logic [31:0] page,
			input logic [1:0] slot, input logic access, input logic sval,
			input logic [7:0] sbyte, input logic stval, input logic lst);
		bot_result_t r;
		r.stage  = xport_stage;
		r.reply  = reply;
		r.page   = page[29:0];
		r.slot   = slot;
		r.access = access;
		r.sval   = sval;
		r.sbyte  = sbyte;
		r.stval  = stval;
		r.lst    = lst;
		due_results.push_back(r);
	endtask

	// Complete wrapper: work out the sector count and the next stage.
	task automatic decode_command(output logic [3:0] reply);
		logic [31:0] count;
		count = xfer_len / BLOCK_BYTES + ((xfer_len % BLOCK_BYTES) != 0);
		sectors_left = count[23:0];
		reply = REPLY_NONE;
		if ((opcode == OP_READ10 || opcode == OP_WRITE10) && sectors_left != 0)
			lba = lba_pending;
		case (opcode)
			OP_SENSE:    reply = REPLY_SENSE;
			OP_INQUIRY:  reply = REPLY_INQUIRY;
			OP_MODE6:    reply = REPLY_MODE6;
			OP_REMOVAL:  reply = REPLY_REMOVAL;
			OP_FMT_CAP:  reply = REPLY_FMT_CAP;
			OP_CAPACITY: reply = REPLY_CAPACITY;
			OP_VERIFY:   reply = REPLY_VERIFY;
			OP_MODE10:   reply = REPLY_MODE10;
			OP_READ10: begin
				fetched_page = NO_PAGE;
				xport_stage  = (sectors_left != 0) ? ST_IN : ST_STS;
			end
			OP_WRITE10: begin
				xport_stage = (sectors_left != 0) ? ST_OUT : ST_STS;
			end
			default: ;
		endcase
		if (reply != REPLY_NONE)
			xport_stage = ST_STS;
	endtask

	task automatic predict_request(input cmd_t c, input logic [7:0] b);
		logic [3:0]  reply;
		logic [31:0] page;
		logic [31:0] rem;
		logic        access;
		logic [7:0]  sb;
		reply = REPLY_NONE;
		case (c)
			CMD_OUT_PKT: begin
				if (xport_stage == ST_IDLE || xport_stage == ST_CMD) begin
					xport_stage = ST_CMD;
					wrap_pos    = '0;
				end
				push_result(REPLY_NONE, '0, '0, 1'b0, 1'b0, '0, 1'b0, 1'b1);
			end
			CMD_WRAP_BYTE: begin
				if (xport_stage == ST_CMD) begin
					if (wrap_pos >= IDX_TAG_LO && wrap_pos <= IDX_TAG_HI)
						cmd_tag[8 * (wrap_pos - IDX_TAG_LO) +: 8] = b;
					else if (wrap_pos >= IDX_LEN_LO && wrap_pos <= IDX_LEN_HI)
						xfer_len[8 * (wrap_pos - IDX_LEN_LO) +: 8] = b;
					else if (wrap_pos == IDX_OPCODE)
						opcode = b;
					else if (wrap_pos >= IDX_LBA_HI && wrap_pos <= IDX_LBA_LO)
						lba_pending[8 * (IDX_LBA_LO - wrap_pos) +: 8] = b;
					if (wrap_pos == IDX_WRAP_END) begin
						wrap_pos = '0;
						decode_command(reply);
					end else begin
						wrap_pos = wrap_pos + 5'd1;
					end
				end
				push_result(reply, '0, '0, 1'b0, 1'b0, '0, 1'b0, 1'b1);
			end
			CMD_SECTOR_DONE: begin
				if (xport_stage == ST_IN || xport_stage == ST_OUT) begin
					page = lba / PAGE_SECTORS;
					rem  = lba % PAGE_SECTORS;
					if (xport_stage == ST_IN) begin
						access       = (page != fetched_page);
						fetched_page = page;
					end else begin
						access = (rem == PAGE_SECTORS - 1) || (sectors_left == 24'd1);
					end
					lba          = lba + 32'd1;
					sectors_left = sectors_left - 24'd1;
					if (sectors_left == 0)
						xport_stage = ST_STS;
					push_result(REPLY_NONE, page, rem[1:0], access, 1'b1, '0, 1'b0, 1'b1);
				end else begin
					push_result(REPLY_NONE, '0, '0, 1'b0, 1'b0, '0, 1'b0, 1'b1);
				end
			end
			default: begin
				if (xport_stage == ST_STS) begin
					xport_stage = ST_IDLE;
					for (int k = 0; k < STATUS_BYTES; k++) begin
						if (k < 4)
							sb = CSW_SIGNATURE[8 * k +: 8];
						else if (k < 8)
							sb = cmd_tag[8 * (k - 4) +: 8];
						else
							sb = '0;
						push_result(REPLY_NONE, '0, '0, 1'b0, 1'b0, sb, 1'b1,
							k == STATUS_BYTES - 1);
					end
				end else begin
					push_result(REPLY_NONE, '0, '0, 1'b0, 1'b0, '0, 1'b0, 1'b1);
				end
			end
		endcase
	endtask

	task automatic check_result();
		bot_result_t w;
		if (due_results.size() == 0) begin
			log_mismatch("result with no request outstanding");
			return;
		end
		w = due_results.pop_front();
		if (stage !== w.stage)
			log_mismatch($sformatf("stage %0d, expected %0d", stage, w.stage));
		if (reply_kind !== w.reply)
			log_mismatch($sformatf("reply_kind %0d, expected %0d", reply_kind, w.reply));
		if (page_number !== w.page)
			log_mismatch($sformatf("page_number %h, expected %h", page_number, w.page));
		if (sector_slot !== w.slot)
			log_mismatch($sformatf("sector_slot %0d, expected %0d", sector_slot, w.slot));
		if (page_access !== w.access)
			log_mismatch($sformatf("page_access %b, expected %b", page_access, w.access));
		if (sector_valid !== w.sval)
			log_mismatch($sformatf("sector_valid %b, expected %b", sector_valid, w.sval));
		if (status_byte !== w.sbyte)
			log_mismatch($sformatf("status_byte %h, expected %h", status_byte, w.sbyte));
		if (status_valid !== w.stval)
			log_mismatch($sformatf("status_valid %b, expected %b", status_valid, w.stval));
		if (last !== w.lst)
			log_mismatch($sformatf("last %b, expected %b", last, w.lst));
		results_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xport_stage  = ST_CMD;
			wrap_pos     = '0;
			cmd_tag      = '0;
			xfer_len     = '0;
			opcode       = '0;
			lba_pending  = '0;
			lba          = '0;
			sectors_left = '0;
			fetched_page = NO_PAGE;
			due_results.delete();
			waiting      = 0;
		end else begin
			if (res_valid && res_ready)
				check_result();
			if (req_valid && req_ready)
				predict_request(cmd_t'(cmd), wrapper_byte);
			waiting = due_results.size();
		end
	end

endmodule

// ----- dv/tb_bulk_only_transport_sequencer.sv -----
// Testbench top for the bulk-only transport sequencer: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps

module tb_bulk_only_transport_sequencer;
	import bots_pkg::*;

	localparam int unsigned SECTOR_SIZE = 512;
	localparam int          WRAP_LEN    = 31;

	// All block inputs start at a known value; reset is held from time zero.
	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        req_valid    = 1'b0;
	logic [1:0]  cmd          = 2'd0;
	logic [7:0]  wrapper_byte = 8'd0;
	logic        res_ready    = 1'b0;

	logic        req_ready;
	logic        res_valid;
	logic [2:0]  stage;
	logic [3:0]  reply_kind;
	logic [29:0] page_number;
	logic [1:0]  sector_slot;
	logic        page_access;
	logic        sector_valid;
	logic [7:0]  status_byte;
	logic        status_valid;
	logic        last;

	int fails;
	int waiting;
	// Percentage of idle slots on both sides; dropped to zero for a calm stretch.
	int idle_pct = 16;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Result side: stall at random, one decision per cycle.
	always @(posedge clk) begin
		res_ready <= ($urandom_range(99) >= idle_pct);
	end

	bulk_only_transport_sequencer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.cmd          (cmd),
		.wrapper_byte (wrapper_byte),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.stage        (stage),
		.reply_kind   (reply_kind),
		.page_number  (page_number),
		.sector_slot  (sector_slot),
		.page_access  (page_access),
		.sector_valid (sector_valid),
		.status_byte  (status_byte),
		.status_valid (status_valid),
		.last         (last)
	);

	bots_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.cmd          (cmd),
		.wrapper_byte (wrapper_byte),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.stage        (stage),
		.reply_kind   (reply_kind),
		.page_number  (page_number),
		.sector_slot  (sector_slot),
		.page_access  (page_access),
		.sector_valid (sector_valid),
		.status_byte  (status_byte),
		.status_valid (status_valid),
		.last         (last),
		.fails        (fails),
		.waiting      (waiting)
	);

	// Hard stop well beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	// Present one request and hold it until the block takes it. An optional
	// one-cycle gap drops valid first; otherwise valid stays high back to back,
	// so valid only ever gets one update per time step.
	task automatic issue(input cmd_t c, input logic [7:0] b);
		if ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid    <= 1'b1;
		cmd          <= c;
		wrapper_byte <= b;
		do @(posedge clk); while (!req_ready);
	endtask

	// Stray event of any kind; only called where it cannot corrupt a wrapper
	// in flight (the stage either ignores it or a following out packet heals it).
	task automatic maybe_noise(input int pct);
		logic [1:0] raw;
		raw = 2'($urandom_range(3));
		if ($urandom_range(99) < pct)
			issue(cmd_t'(raw), 8'($urandom));
	endtask

	// Hold off the sender until every outstanding result has come back.
	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (waiting != 0);
	endtask

	// One full transport: out packet, 31-byte wrapper, sector events for a
	// data command, then the status request. With noise enabled, abandon a
	// wrapper part way first and sprinkle stray events between the phases.
	task automatic run_command(input logic [7:0] op, input logic [31:0] len,
			input logic [31:0] lba, input logic [31:0] tag, input int noise_pct);
		logic [7:0] cbw [WRAP_LEN];
		int         sectors;
		for (int k = 0; k < WRAP_LEN; k++)
			cbw[k] = 8'($urandom);
		for (int k = 0; k < 4; k++) begin
			cbw[IDX_TAG_LO + k] = tag[8 * k +: 8];
			cbw[IDX_LEN_LO + k] = len[8 * k +: 8];
			// block address goes out most significant byte first
			cbw[IDX_LBA_HI + k] = lba[8 * (3 - k) +: 8];
		end
		cbw[IDX_OPCODE] = op;
		sectors = 0;
		if (op == OP_READ10 || op == OP_WRITE10)
			sectors = int'((len + SECTOR_SIZE - 1) / SECTOR_SIZE);

		maybe_noise(noise_pct);
		issue(CMD_OUT_PKT, 8'($urandom));
		if ($urandom_range(99) < noise_pct) begin
			repeat ($urandom_range(1, WRAP_LEN - 1)) issue(CMD_WRAP_BYTE, 8'($urandom));
			issue(CMD_OUT_PKT, 8'($urandom));
		end
		for (int k = 0; k < WRAP_LEN; k++)
			issue(CMD_WRAP_BYTE, cbw[k]);
		// overshoot now and then: extra sector events land in the status stage
		if (noise_pct > 0 && $urandom_range(3) == 0)
			sectors++;
		for (int k = 0; k < sectors; k++) begin
			maybe_noise(noise_pct);
			issue(CMD_SECTOR_DONE, 8'($urandom));
		end
		maybe_noise(noise_pct);
		issue(CMD_STATUS, 8'($urandom));
	endtask

	initial begin
		logic [7:0] op;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Command stage straight out of reset: sector and status events are dropped.
		issue(CMD_SECTOR_DONE, 8'h00);
		issue(CMD_STATUS, 8'hFF);

		// One canned reply picked at random, with all-ones fields.
		case ($urandom_range(7))
			0:       op = OP_SENSE;
			1:       op = OP_INQUIRY;
			2:       op = OP_MODE6;
			3:       op = OP_REMOVAL;
			4:       op = OP_FMT_CAP;
			5:       op = OP_CAPACITY;
			6:       op = OP_VERIFY;
			default: op = OP_MODE10;
		endcase
		run_command(op, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		// idle stage: wrapper byte, sector and status events are all dropped
		issue(CMD_WRAP_BYTE, 8'hA5);
		issue(CMD_SECTOR_DONE, 8'h5A);
		issue(CMD_STATUS, 8'h00);

		// Unknown opcode: no reply, stage stays command, status is ignored.
		run_command(8'hFF, SECTOR_SIZE, 32'd7, $urandom, 0);

		// Calm stretch with no idling on either side. Reads crossing a page,
		// then a read starting in the page just fetched: the first sector of a
		// read must fetch regardless.
		idle_pct = 0;
		run_command(OP_READ10, 5 * SECTOR_SIZE, 32'd2, $urandom, 0);
		run_command(OP_READ10, 2 * SECTOR_SIZE - 1, 32'd6, $urandom, 0);
		idle_pct = 16;

		// Write wrapping past the top of the address range: program on the
		// last slot of a page and on the last sector.
		run_command(OP_WRITE10, 4 * SECTOR_SIZE - 511, 32'hFFFF_FFFE, $urandom, 0);
		// Zero-length data command goes straight to status.
		run_command(OP_READ10, 32'h0, $urandom, $urandom, 0);

		drain();

		// Broken wrapper restart and stray events in every stage.
		run_command(OP_WRITE10, 3 * SECTOR_SIZE, $urandom, $urandom, 100);

		// Stop sending, let outstanding results drain, then watch for strays.
		req_valid <= 1'b0;
		for (int n = 0; n < 20000 && waiting != 0; n++)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (fails == 0 && waiting == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/bots_pkg.sv
hdl/bots_cdiv.sv
hdl/bots_core.sv
hdl/bots_out.sv
hdl/bulk_only_transport_sequencer.sv
dv/bots_checker.sv
dv/tb_bulk_only_transport_sequencer.sv
